FILE: src/chunked_transfer_crc_checker_core_defines.svh
// Assertion macros for the chunked transfer CRC checker.
// CTCC_ASSERT holds outside reset; CTCC_ASSERT_ALWAYS is also checked while reset is low.
`ifndef CHUNKED_TRANSFER_CRC_CHECKER_CORE_DEFINES_SVH
`define CHUNKED_TRANSFER_CRC_CHECKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CTCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CTCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTCC_ASSERT(label, prop, msg)
`define CTCC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/ctcc_pkg.sv
`default_nettype none
package ctcc_pkg;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'h8408;
	localparam logic [7:0]  ACK_CODE       = 8'hAA;
	localparam logic [7:0]  NACK_CODE      = 8'h55;
	localparam logic [10:0] CRC_PACKET_LEN = 11'd2;
	localparam logic [12:0] LIMIT_RESET    = 13'd6000;
	localparam logic [7:0]  INDEX_RESET    = 8'd6;
	localparam logic [12:0] COUNT_MAX      = 13'd8191;
	localparam logic [7:0]  CHUNK_MAX      = 8'd255;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_CRC    = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_BYTE_LIMIT      = 1'b0,
		REG_CRC_CHUNK_INDEX = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [12:0] byte_limit;
		logic [7:0]  crc_chunk_index;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [10:0] packet_length;
		logic        first_of_packet;
		logic        last_of_packet;
	} item_t;

	typedef struct packed {
		logic [7:0]  reply_code;
		logic        transfer_complete;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
		logic [12:0] bytes_held;
		logic [7:0]  chunks_held;
	} result_t;

	// CRC-16/X-25 byte update, reflected, LSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/ctcc_cfg.sv
`default_nettype none
module ctcc_cfg
	import ctcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_limit      <= LIMIT_RESET;
			cfg_q.crc_chunk_index <= INDEX_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BYTE_LIMIT:      cfg_q.byte_limit      <= cfg_data;
				REG_CRC_CHUNK_INDEX: cfg_q.crc_chunk_index <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: src/ctcc_engine.sv
`default_nettype none
module ctcc_engine
	import ctcc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  take,
	input  wire item_t item,
	input  wire logic  res_ready,
	output logic       res_valid,
	output result_t    res
);

	logic [15:0] crc_q;
	logic [12:0] bytes_q;
	logic [7:0]  chunks_q;
	kind_t       kind_q;
	logic [7:0]  low_q;
	logic        res_valid_q;
	result_t     res_q;

	kind_t       kind_new;
	logic [15:0] crc_next;
	logic [12:0] bytes_next;
	logic [7:0]  chunks_next;
	logic [7:0]  chunk_inc;
	logic [7:0]  low_next;
	logic [13:0] fill_sum;
	logic [15:0] rcrc;
	logic        crc_match;
	result_t     res_next;

	always_comb begin
		fill_sum = {1'b0, bytes_q} + {3'b000, item.packet_length};
		kind_new = kind_q;
		if (item.first_of_packet) begin
			priority if (item.packet_length == CRC_PACKET_LEN
			             && chunks_q == cfg.crc_chunk_index) begin
				kind_new = KIND_CRC;
			end else if (fill_sum <= {1'b0, cfg.byte_limit}) begin
				kind_new = KIND_DATA;
			end else begin
				kind_new = KIND_REJECT;
			end
		end

		crc_next   = crc_q;
		bytes_next = bytes_q;
		if (kind_new == KIND_DATA) begin
			crc_next = crc_update(crc_q, item.data_byte);
			if (bytes_q != COUNT_MAX) begin
				bytes_next = bytes_q + 13'd1;
			end
		end

		low_next = (item.first_of_packet && kind_new == KIND_CRC) ? item.data_byte : low_q;
		// a one-byte CRC packet uses the same byte as low and high half
		rcrc      = {item.data_byte, low_next};
		crc_match = (rcrc == ~crc_next);
		chunk_inc = (chunks_q == CHUNK_MAX) ? CHUNK_MAX : chunks_q + 8'd1;

		chunks_next                = chunks_q;
		res_next.reply_code        = ACK_CODE;
		res_next.transfer_complete = 1'b0;
		res_next.computed_crc      = ~crc_next;
		res_next.received_crc      = 16'h0000;
		res_next.bytes_held        = bytes_next;
		res_next.chunks_held       = chunks_q;
		priority if (kind_new == KIND_DATA) begin
			if (item.last_of_packet) begin
				chunks_next = chunk_inc;
			end
			res_next.chunks_held = chunk_inc;
		end else if (kind_new == KIND_REJECT) begin
			res_next.reply_code = NACK_CODE;
		end else begin
			res_next.received_crc = rcrc;
			if (crc_match) begin
				res_next.transfer_complete = 1'b1;
				res_next.chunks_held       = chunk_inc;
			end else begin
				res_next.reply_code = NACK_CODE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			bytes_q  <= '0;
			chunks_q <= '0;
			kind_q   <= KIND_DATA;
			low_q    <= '0;
		end else if (take) begin
			if (item.last_of_packet && res_next.transfer_complete) begin
				crc_q    <= CRC_INIT;
				bytes_q  <= '0;
				chunks_q <= '0;
				kind_q   <= KIND_DATA;
				low_q    <= '0;
			end else begin
				crc_q    <= crc_next;
				bytes_q  <= bytes_next;
				chunks_q <= chunks_next;
				kind_q   <= kind_new;
				low_q    <= low_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && item.last_of_packet) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last_of_packet) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

FILE: src/chunked_transfer_crc_checker_core.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, packet_length, first_of_packet, last_of_packet
// output    out_valid / out_ready  reply_code, transfer_complete, computed_crc, received_crc,
//                                  bytes_held, chunks_held
// config    cfg_write              cfg_index, cfg_data
//
// One byte per cycle while the input is not stalled. A byte goes through the
// input register, then the CRC and count update lands in the state and, on a
// last byte, in the output register, from which the result is offered.
// Reset is asynchronous and clears the engine state and both valid flags; no clearing pass.
// Only a last byte waiting behind an untaken result stalls the input.
`default_nettype none
`include "chunked_transfer_crc_checker_core_defines.svh"
module chunked_transfer_crc_checker_core
	import ctcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic [10:0] packet_length,
	input  wire logic        first_of_packet,
	input  wire logic        last_of_packet,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       reply_code,
	output logic             transfer_complete,
	output logic [15:0]      computed_crc,
	output logic [15:0]      received_crc,
	output logic [12:0]      bytes_held,
	output logic [7:0]       chunks_held
);

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	logic    take;
	result_t res;
	logic    out_ack;
	logic    out_data_ack;

	ctcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held byte moves on unless it ends a packet and the result slot is full
	assign take     = valid_s1 && (!item_s1.last_of_packet || !out_valid || out_ready);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte       <= data_byte;
			item_s1.packet_length   <= packet_length;
			item_s1.first_of_packet <= first_of_packet;
			item_s1.last_of_packet  <= last_of_packet;
		end
	end

	ctcc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.item      (item_s1),
		.res_ready (out_ready),
		.res_valid (out_valid),
		.res       (res)
	);

	assign reply_code        = res.reply_code;
	assign transfer_complete = res.transfer_complete;
	assign computed_crc      = res.computed_crc;
	assign received_crc      = res.received_crc;
	assign bytes_held        = res.bytes_held;
	assign chunks_held       = res.chunks_held;

	assign out_ack      = out_valid && reply_code == ACK_CODE;
	assign out_data_ack = out_ack && !transfer_complete;

	`CTCC_ASSERT(a_done_is_ack, out_valid && transfer_complete |-> out_ack, "completion without ACK")
	`CTCC_ASSERT(a_data_rcrc, out_data_ack |-> received_crc == '0, "CRC on data ACK")
	`CTCC_ASSERT(a_stall, !in_ready |-> out_valid && !out_ready, "stall without blocked result")
	`CTCC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid && !valid_s1, "valid in reset")

endmodule
`default_nettype wire
